// File: hdl/assert_macros.svh
// Assertion macros shared by the prefetch timing RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset
`define CPT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Same-cycle implication checked outside reset
`define CPT_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define CPT_ASSERT(name, prop, msg)
`define CPT_ASSERT_IMPL(name, ante, cons, msg)
`endif
`endif

// File: hdl/cpt_pkg.sv
// Types, constants and wait-table functions of the prefetch timing block
package cpt_pkg;

  localparam int unsigned THUMB_CAPACITY = 8;
  localparam int unsigned ARM_CAPACITY   = 4;

  localparam int unsigned CNT_W  = 4;
  localparam int unsigned DUTY_W = 6;
  localparam int unsigned CD_W   = 11;

  localparam logic [31:0] ROM_LO = 32'h0800_0000;
  localparam logic [31:0] ROM_HI = 32'h0DFF_FFFF;

  localparam logic signed [CD_W-1:0] CD_FLOOR = -11'sd1023;
  localparam logic signed [CD_W-1:0] CD_MAX   = 11'sd63;

  localparam logic KIND_IDLE   = 1'b0;
  localparam logic KIND_ACCESS = 1'b1;

  typedef enum logic [2:0] {
    CFG_SRAM_WAIT  = 3'd0,
    CFG_WS0_NONSEQ = 3'd1,
    CFG_WS0_SEQ    = 3'd2,
    CFG_WS1_NONSEQ = 3'd3,
    CFG_WS1_SEQ    = 3'd4,
    CFG_WS2_NONSEQ = 3'd5,
    CFG_WS2_SEQ    = 3'd6,
    CFG_PREFETCH   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] address;
    logic        is_code;
    logic [7:0]  access_cycles;
    logic        thumb_mode;
    logic [31:0] program_counter;
    logic        buffer_was_disabled;
    logic        dma_started;
    logic [15:0] dma_duration;
    logic [4:0]  page_seq_wait16;
    logic [5:0]  page_seq_wait32;
  } item_t;

  typedef struct packed {
    logic [8:0] charged_cycles;
    logic       disabled_flag_cleared;
  } result_t;

  typedef struct packed {
    logic [1:0] sram_wait_sel;
    logic [1:0] ws0_nonseq_sel;
    logic       ws0_seq_sel;
    logic [1:0] ws1_nonseq_sel;
    logic       ws1_seq_sel;
    logic [1:0] ws2_nonseq_sel;
    logic       ws2_seq_sel;
    logic       prefetch_enable;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic step;
    logic push;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic refill;
    logic cd_le0;
    logic step_last;
    logic out_free;
  } status_t;

  function automatic logic [3:0] nseq_wait(input logic [1:0] sel);
    logic [3:0] w;
    case (sel)
      2'd0:    w = 4'd5;
      2'd1:    w = 4'd4;
      2'd2:    w = 4'd3;
      default: w = 4'd9;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] s0_wait(input logic sel);
    return sel ? 4'd2 : 4'd3;
  endfunction

  function automatic logic [3:0] s1_wait(input logic sel);
    return sel ? 4'd2 : 4'd5;
  endfunction

  function automatic logic [3:0] s2_wait(input logic sel);
    return sel ? 4'd2 : 4'd9;
  endfunction

  // 16-bit sequential wait of a page
  function automatic logic [4:0] seq16(input logic [7:0] page, input logic [4:0] in16,
                                       input cfg_t cfg);
    logic [4:0] w;
    case (page) inside
      8'h08, 8'h09: w = {1'b0, s0_wait(cfg.ws0_seq_sel)};
      8'h0A, 8'h0B: w = {1'b0, s1_wait(cfg.ws1_seq_sel)};
      8'h0C, 8'h0D: w = {1'b0, s2_wait(cfg.ws2_seq_sel)};
      8'h0E, 8'h0F: w = {1'b0, nseq_wait(cfg.sram_wait_sel)};
      default:      w = in16;
    endcase
    return w;
  endfunction

  // 32-bit sequential wait of a page
  function automatic logic [5:0] seq32(input logic [7:0] page, input logic [5:0] in32,
                                       input cfg_t cfg);
    logic [4:0] s;
    logic [5:0] w;
    s = seq16(page, 5'd0, cfg);
    case (page) inside
      [8'h08:8'h0D]: w = {s, 1'b0};
      8'h0E, 8'h0F:  w = {2'b0, nseq_wait(cfg.sram_wait_sel)};
      default:       w = in32;
    endcase
    return w;
  endfunction

  function automatic logic [CNT_W-1:0] capacity(input logic thumb);
    return thumb ? CNT_W'(THUMB_CAPACITY) : CNT_W'(ARM_CAPACITY);
  endfunction

  function automatic logic [2:0] fetch_width(input logic thumb);
    return thumb ? 3'd2 : 3'd4;
  endfunction

endpackage

// File: hdl/cpt_if.sv
// Handshake channels of the prefetch timing block

// Input item channel
interface cpt_item_if;
  logic           valid;
  logic           ready;
  cpt_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel
interface cpt_result_if;
  logic             valid;
  logic             ready;
  cpt_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel
interface cpt_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: hdl/cpt_ctrl.sv
// Sequencing state machine of the prefetch timing block
`include "assert_macros.svh"

module cpt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cpt_pkg::status_t  status_i,
  output cpt_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_FILL = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.eval = 1'b1;
        state_d    = status_i.refill ? S_FILL : S_DONE;
      end
      S_FILL: begin
        if (status_i.cd_le0) begin
          cmd_o.step = 1'b1;
          if (status_i.step_last) begin
            state_d = S_DONE;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `CPT_ASSERT(a_accept_to_calc, (in_valid_i && in_ready_o) |=> (state_q == S_CALC), "accepted transfer did not start evaluation")
  `CPT_ASSERT_IMPL(a_push_when_free, cmd_o.push, status_i.out_free, "result pushed over a pending one")
  `CPT_ASSERT_IMPL(a_step_when_due, cmd_o.step, status_i.cd_le0, "refill step with countdown running")

endmodule

// File: hdl/cpt_datapath.sv
// Buffer state, wait tables, charge computation and result register
`include "assert_macros.svh"

module cpt_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cpt_pkg::item_t    item_i,
  input  logic              cfg_valid_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output cpt_pkg::result_t  out_data_o,
  input  cpt_pkg::cmd_t     cmd_i,
  output cpt_pkg::status_t  status_o
);

  localparam int unsigned CW = cpt_pkg::CNT_W;
  localparam int unsigned DW = cpt_pkg::DUTY_W;
  localparam int unsigned KW = cpt_pkg::CD_W;

  cpt_pkg::cfg_t    cfg_q, cfg_d;
  cpt_pkg::item_t   it_q;
  cpt_pkg::result_t res_q;
  logic             out_valid_q, out_valid_d;

  logic                 active_q, active_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 thumb_q, thumb_d;
  logic [DW-1:0]        duty_q, duty_d;
  logic signed [KW-1:0] cd_q, cd_d;
  logic [31:0]          head_q, head_d;
  logic [31:0]          fetch_q, fetch_d;
  logic [15:0]          free_q, free_d;
  logic [8:0]           charged_q, charged_d;
  logic                 cleared_q, cleared_d;
  logic                 infl_q, infl_d;

  logic [7:0]           page;
  logic [4:0]           s16;
  logic [5:0]           s32;
  logic [CW-1:0]        cap_cur;
  logic [2:0]           w_cur;
  logic [2:0]           w_new;
  logic                 cd_pos;
  logic                 cd_le0;
  logic                 in_rom;
  logic signed [KW-1:0] half;
  logic                 pen;
  logic [7:0]           n16;
  logic [7:0]           cycf;
  logic [15:0]          free_win;
  logic                 is_idle, is_noncode, is_hit, is_infl, is_full;
  logic                 refill;
  logic signed [KW-1:0] cd_dec;
  logic [CW-1:0]        cnt_step;
  logic                 step_last;
  logic [DW-1:0]        duty_new;
  logic [31:0]          fetch_new;

  // Decode the held item against the buffer state
  always_comb begin
    page     = it_q.address[31:24];
    s16      = cpt_pkg::seq16(page, it_q.page_seq_wait16, cfg_q);
    s32      = cpt_pkg::seq32(page, it_q.page_seq_wait32, cfg_q);
    cap_cur  = cpt_pkg::capacity(thumb_q);
    w_cur    = cpt_pkg::fetch_width(thumb_q);
    w_new    = cpt_pkg::fetch_width(it_q.thumb_mode);
    cd_le0   = cd_q[KW-1] || (cd_q == '0);
    cd_pos   = !cd_le0;
    in_rom   = (it_q.program_counter >= cpt_pkg::ROM_LO) &&
               (it_q.program_counter <= cpt_pkg::ROM_HI);
    half     = $signed({{(KW-DW+1){1'b0}}, duty_q[DW-1:1]}) + 11'sd1;
    pen      = active_q && in_rom &&
               ((cd_q == 11'sd1) || (!thumb_q && (cd_q == half)));
    n16      = {4'b0, cpt_pkg::nseq_wait(cfg_q.ws0_nonseq_sel)};
    cycf     = it_q.access_cycles;
    if (it_q.buffer_was_disabled) begin
      if (it_q.access_cycles == {3'b0, s16}) begin
        cycf = n16;
      end else if (it_q.access_cycles == {2'b0, s32}) begin
        cycf = n16 + {4'b0, cpt_pkg::s0_wait(cfg_q.ws0_seq_sel)};
      end
    end
    free_win   = it_q.dma_started ? it_q.dma_duration : free_q;
    is_idle    = (it_q.kind == cpt_pkg::KIND_IDLE);
    is_noncode = (it_q.kind == cpt_pkg::KIND_ACCESS) && !it_q.is_code;
    is_hit     = (it_q.kind == cpt_pkg::KIND_ACCESS) && it_q.is_code && active_q &&
                 (cnt_q != '0) && (it_q.address == head_q);
    is_infl    = (it_q.kind == cpt_pkg::KIND_ACCESS) && it_q.is_code && !is_hit &&
                 active_q && cd_pos && (it_q.address == fetch_q);
    is_full    = (it_q.kind == cpt_pkg::KIND_ACCESS) && it_q.is_code && !is_hit && !is_infl;
    refill     = (is_idle && (free_win == '0) && active_q) || is_hit || is_infl;
    cd_dec     = (cd_q == cpt_pkg::CD_FLOOR) ? cd_q : (cd_q - 11'sd1);
    cnt_step   = (cnt_q < cap_cur) ? (cnt_q + 1'b1) : cnt_q;
    step_last  = !(cfg_q.prefetch_enable && (cnt_step < cap_cur));
    duty_new   = it_q.thumb_mode ? {1'b0, s16} : s32;
    fetch_new  = it_q.address + {29'b0, w_new};
  end

  assign status_o.refill    = refill;
  assign status_o.cd_le0    = cd_le0;
  assign status_o.step_last = step_last;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Next buffer state per command
  always_comb begin
    active_d    = active_q;
    cnt_d       = cnt_q;
    thumb_d     = thumb_q;
    duty_d      = duty_q;
    cd_d        = cd_q;
    head_d      = head_q;
    fetch_d     = fetch_q;
    free_d      = free_q;
    charged_d   = charged_q;
    cleared_d   = cleared_q;
    infl_d      = infl_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.eval) begin
      charged_d = '0;
      cleared_d = 1'b0;
      infl_d    = is_infl;
      if (is_idle) begin
        free_d = (free_win == '0) ? '0 : (free_win - 16'd1);
        if (free_win == '0) begin
          charged_d = 9'd1;
          if (active_q) begin
            cd_d = cd_dec;
          end
        end
      end else if (is_noncode) begin
        charged_d = {1'b0, it_q.access_cycles} + {8'b0, pen};
        active_d  = 1'b0;
      end else if (is_hit) begin
        charged_d = 9'd1;
        cnt_d     = cnt_q - 1'b1;
        head_d    = head_q + {29'b0, w_cur};
        cd_d      = cd_dec;
      end else if (is_infl) begin
        charged_d = {3'b0, cd_q[DW-1:0]};
        cd_d      = '0;
      end else begin
        charged_d = {1'b0, cycf} + {8'b0, pen};
        cleared_d = it_q.buffer_was_disabled;
        if (cfg_q.prefetch_enable) begin
          active_d = 1'b1;
          cnt_d    = '0;
          thumb_d  = it_q.thumb_mode;
          duty_d   = duty_new;
          cd_d     = $signed({{(KW-DW){1'b0}}, duty_new});
          fetch_d  = fetch_new;
          head_d   = fetch_new;
        end else begin
          active_d = 1'b0;
        end
      end
    end
    // One refill iteration
    if (cmd_i.step) begin
      cnt_d = cnt_step;
      if (!step_last) begin
        fetch_d = fetch_q + {29'b0, w_cur};
        cd_d    = cd_q + $signed({{(KW-DW){1'b0}}, duty_q});
      end
    end
    // Finish an in-flight hit and hand over the result
    if (cmd_i.push) begin
      if (infl_q) begin
        head_d = fetch_q;
        cnt_d  = '0;
      end
      out_valid_d = 1'b1;
    end
  end

  // Configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cpt_pkg::cfg_idx_e'(cfg_index_i))
        cpt_pkg::CFG_SRAM_WAIT:  cfg_d.sram_wait_sel   = cfg_wdata_i[1:0];
        cpt_pkg::CFG_WS0_NONSEQ: cfg_d.ws0_nonseq_sel  = cfg_wdata_i[1:0];
        cpt_pkg::CFG_WS0_SEQ:    cfg_d.ws0_seq_sel     = cfg_wdata_i[0];
        cpt_pkg::CFG_WS1_NONSEQ: cfg_d.ws1_nonseq_sel  = cfg_wdata_i[1:0];
        cpt_pkg::CFG_WS1_SEQ:    cfg_d.ws1_seq_sel     = cfg_wdata_i[0];
        cpt_pkg::CFG_WS2_NONSEQ: cfg_d.ws2_nonseq_sel  = cfg_wdata_i[1:0];
        cpt_pkg::CFG_WS2_SEQ:    cfg_d.ws2_seq_sel     = cfg_wdata_i[0];
        cpt_pkg::CFG_PREFETCH:   cfg_d.prefetch_enable = cfg_wdata_i[0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  // Hold control state, configuration and buffer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      active_q    <= 1'b0;
      cnt_q       <= '0;
      thumb_q     <= 1'b0;
      duty_q      <= '0;
      cd_q        <= '0;
      head_q      <= '0;
      fetch_q     <= '0;
      free_q      <= '0;
      infl_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      active_q    <= active_d;
      cnt_q       <= cnt_d;
      thumb_q     <= thumb_d;
      duty_q      <= duty_d;
      cd_q        <= cd_d;
      head_q      <= head_d;
      fetch_q     <= fetch_d;
      free_q      <= free_d;
      infl_q      <= infl_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the item, the running charge and the result payload
  always_ff @(posedge clk_i) begin
    charged_q <= charged_d;
    cleared_q <= cleared_d;
    if (cmd_i.load) begin
      it_q <= item_i;
    end
    if (cmd_i.push) begin
      res_q.charged_cycles        <= charged_q;
      res_q.disabled_flag_cleared <= cleared_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  `CPT_ASSERT(a_cnt_capped, (cnt_q <= cap_cur), "buffered count above capacity")
  `CPT_ASSERT(a_cd_floor, (cd_q >= cpt_pkg::CD_FLOOR), "countdown below floor")
  `CPT_ASSERT(a_cd_ceiling, (cd_q <= cpt_pkg::CD_MAX), "countdown above largest duty")

endmodule

// File: hdl/cartridge_prefetch_timing.sv
// Cartridge prefetch buffer timing: an item is accepted, evaluated and handed over, with an
// optional refill loop before hand-over that buffers one fetch per cycle up to the capacity
// (8 in Thumb, 4 in ARM); the next item is taken as soon as the result sits in the output
// register, and a result still waiting there holds the hand-over and so stalls the next item.
// Reset clears the buffer state, the DMA window and all configuration registers
// to zero and empties the output register; no clearing pass is needed.
module cartridge_prefetch_timing (
  input logic           clk_i,
  input logic           rst_ni,
  cpt_item_if.sink      item_i,
  cpt_cfg_if.sink       cfg_i,
  cpt_result_if.source  result_o
);

  cpt_pkg::cmd_t    cmd;
  cpt_pkg::status_t status;

  // Configuration is always taken
  assign cfg_i.ready = 1'b1;

  cpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cpt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_wdata_i (cfg_i.wdata),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .out_data_o  (result_o.data),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
